### design/aho_corasick_word_phrase_matcher_unit_assert.svh
// Assertion macros for the phrase matcher top level.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef AHO_CORASICK_WORD_PHRASE_MATCHER_UNIT_ASSERT_SVH
`define AHO_CORASICK_WORD_PHRASE_MATCHER_UNIT_ASSERT_SVH
// same-cycle implication
`define ACWPM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("acwpm assertion failed");
// next-cycle implication
`define ACWPM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("acwpm assertion failed");
`endif

### design/acwpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acwpm_pkg
// Types, table sizes, item codes and helpers of the phrase matcher.
// ----------------------------------------------------------------------------
package acwpm_pkg;

  localparam int NODE_DEPTH           = 4096;
  localparam int TRANSITION_DEPTH     = 8192;
  localparam int OUTPUT_DEPTH         = 8192;
  localparam int PATTERN_DEPTH        = 1024;
  localparam int MAX_PATTERN_LEN      = 256;
  localparam int MAX_OUTPUTS_PER_NODE = 16;
  localparam int RESULT_LIMIT         = 32;
  localparam int TRANS_SCAN_MAX       = 256;
  localparam int HIST_LEN             = MAX_PATTERN_LEN + 1;

  localparam int NODE_AW  = $clog2(NODE_DEPTH);
  localparam int TRANS_AW = $clog2(TRANSITION_DEPTH);
  localparam int OUT_AW   = $clog2(OUTPUT_DEPTH);
  localparam int PAT_AW   = $clog2(PATTERN_DEPTH);
  localparam int HIST_AW  = $clog2(HIST_LEN);
  localparam int STEP_W   = $clog2(NODE_DEPTH + 1);
  localparam int CNT_W    = $clog2(RESULT_LIMIT + 1);

  localparam logic [2:0] MODE_NODE  = 3'd0;
  localparam logic [2:0] MODE_TRANS = 3'd1;
  localparam logic [2:0] MODE_OUT   = 3'd2;
  localparam logic [2:0] MODE_LEN   = 3'd3;
  localparam logic [2:0] MODE_TEXT  = 3'd4;

  localparam logic [7:0] CH_LC_A = 8'h61;
  localparam logic [7:0] CH_LC_Z = 8'h7a;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_USCR = 8'h5f;

  typedef struct packed {
    logic [2:0]  mode;
    logic [12:0] index;
    logic [11:0] fail_node;
    logic [12:0] trans_start;
    logic [8:0]  trans_count;
    logic [12:0] out_start;
    logic [4:0]  out_count;
    logic [7:0]  byte_value;
    logic [11:0] target_value;
    logic        last_byte;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  pattern_number;
    logic [31:0] match_begin;
    logic [31:0] match_end;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [11:0] fail;
    logic [12:0] tstart;
    logic [8:0]  tcount;
    logic [12:0] ostart;
    logic [4:0]  ocount;
  } node_t;

  typedef struct packed {
    logic [7:0]  key;
    logic [11:0] target;
  } trans_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EM_NODE, ST_EM_SCAN, ST_EM_PAT, ST_EM_LEN, ST_EM_HB, ST_EM_HE,
    ST_EM_PUSH, ST_HIST_WR, ST_WK_NODE, ST_WK_SCAN, ST_WK_KEY, ST_UPDATE, ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic text_start;
    logic em_final;
    logic node_rd;
    logic node_sel_walk;
    logic k_inc;
    logic out_rd;
    logic len_rd;
    logic hist_rd;
    logic hist_sel;
    logic push;
    logic flush;
    logic hist_wr;
    logic trans_rd;
    logic i_inc;
    logic wk_fail;
    logic wk_root;
    logic nxt_hit;
    logic nxt_zero;
    logic update;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic pend_valid;
    logic last;
    logic k_done;
    logic a_ok;
    logic pat_ok;
    logic len_ok;
    logic suppress;
    logic need_before;
    logic hist_flag;
    logic newest;
    logic limit;
    logic staged_valid;
    logic out_space;
    logic t_done;
    logic s_zero;
    logic steps_max;
    logic key_hit;
  } sts_t;

  function automatic logic is_word(input logic [7:0] b);
    is_word = (b >= CH_LC_A && b <= CH_LC_Z) || (b >= CH_0 && b <= CH_9) ||
              (b == CH_USCR);
  endfunction

  function automatic logic [NODE_AW-1:0] node_ref(input logic [11:0] v);
    node_ref = (32'(v) < NODE_DEPTH) ? v[NODE_AW-1:0] : '0;
  endfunction

  function automatic logic [31:0] sat32(input logic [32:0] v);
    sat32 = v[32] ? '1 : v[31:0];
  endfunction

endpackage
`default_nettype wire

### design/acwpm_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acwpm_dp
// Tables, walk and match registers, staging and output register.
// ----------------------------------------------------------------------------
module acwpm_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  acwpm_pkg::in_item_t  in_data,
  input  acwpm_pkg::cmd_t      cmd,
  output acwpm_pkg::sts_t      sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output acwpm_pkg::out_item_t out_data
);

  acwpm_pkg::node_t  node_mem  [acwpm_pkg::NODE_DEPTH];
  acwpm_pkg::trans_t trans_mem [acwpm_pkg::TRANSITION_DEPTH];
  logic [9:0]        olist_mem [acwpm_pkg::OUTPUT_DEPTH];
  logic [8:0]        plen_mem  [acwpm_pkg::PATTERN_DEPTH];
  logic              hist_mem  [acwpm_pkg::HIST_LEN];

  acwpm_pkg::node_t  node_q;
  acwpm_pkg::trans_t trans_q;
  logic [9:0]        out_q;
  logic [8:0]        len_q;
  logic              hist_q;

  logic [7:0]                      c_r;
  logic                            last_r;
  logic                            w_r;
  logic [acwpm_pkg::NODE_AW-1:0]   cur_node_r;
  logic [31:0]                     pos_r;
  logic                            pend_valid_r;
  logic [acwpm_pkg::NODE_AW-1:0]   pend_node_r;
  logic [32:0]                     pend_end_r;
  logic [32:0]                     end_r;
  logic [acwpm_pkg::HIST_AW-1:0]   head_r;
  logic                            newest_r;
  logic [acwpm_pkg::NODE_AW-1:0]   s_r;
  logic [acwpm_pkg::STEP_W-1:0]    steps_r;
  logic [acwpm_pkg::NODE_AW-1:0]   nxt_r;
  logic [8:0]                      i_r;
  logic [4:0]                      k_r;
  logic [acwpm_pkg::CNT_W-1:0]     cnt_r;
  logic                            staged_valid_r;
  acwpm_pkg::out_item_t            staged_r;
  logic                            out_valid_r;
  acwpm_pkg::out_item_t            out_r;

  logic                            in_node_ok, in_trans_ok, in_out_ok, in_len_ok;
  logic [acwpm_pkg::NODE_AW-1:0]   emit_node, node_ra;
  logic [32:0]                     emit_end, end_nxt, begin_v;
  logic [4:0]                      oc;
  logic [13:0]                     out_a, trans_a;
  logic [8:0]                      tc;
  logic [acwpm_pkg::HIST_AW-1:0]   hk, ha, head_inc;
  logic                            out_space;
  acwpm_pkg::out_item_t            new_item;
  acwpm_pkg::out_item_t            flush_item;
  acwpm_pkg::node_t                node_wd;

  always_comb begin
    in_node_ok  = 32'(in_data.index) < acwpm_pkg::NODE_DEPTH;
    in_trans_ok = 32'(in_data.index) < acwpm_pkg::TRANSITION_DEPTH;
    in_out_ok   = 32'(in_data.index) < acwpm_pkg::OUTPUT_DEPTH;
    in_len_ok   = 32'(in_data.index) < acwpm_pkg::PATTERN_DEPTH;
    node_wd.fail   = in_data.fail_node;
    node_wd.tstart = in_data.trans_start;
    node_wd.tcount = in_data.trans_count;
    node_wd.ostart = in_data.out_start;
    node_wd.ocount = in_data.out_count;

    emit_node = cmd.em_final ? cur_node_r : pend_node_r;
    emit_end  = cmd.em_final ? end_r : pend_end_r;
    node_ra   = cmd.node_sel_walk ? s_r : emit_node;

    oc = (32'(node_q.ocount) > acwpm_pkg::MAX_OUTPUTS_PER_NODE) ?
         5'(acwpm_pkg::MAX_OUTPUTS_PER_NODE) : node_q.ocount;
    out_a = {1'b0, node_q.ostart} + {9'b0, k_r};
    tc = (32'(node_q.tcount) > acwpm_pkg::TRANS_SCAN_MAX) ?
         9'(acwpm_pkg::TRANS_SCAN_MAX) : node_q.tcount;
    trans_a = {1'b0, node_q.tstart} + {5'b0, i_r};

    // ring distance back from the newest flag
    hk = acwpm_pkg::HIST_AW'(cmd.hist_sel ? (len_q - 9'd1) : len_q);
    if (head_r >= hk) begin
      ha = head_r - hk;
    end else begin
      ha = acwpm_pkg::HIST_AW'({1'b0, head_r} +
           (acwpm_pkg::HIST_AW + 1)'(acwpm_pkg::HIST_LEN) - {1'b0, hk});
    end
    head_inc = (32'(head_r) == acwpm_pkg::HIST_LEN - 1) ? '0 : head_r + 1'b1;

    end_nxt = {1'b0, pos_r} + 33'd1;
    begin_v = emit_end - {24'b0, len_q};
    out_space = !out_valid_r || out_ready;

    new_item.pattern_number = out_q;
    new_item.match_begin    = acwpm_pkg::sat32(begin_v);
    new_item.match_end      = acwpm_pkg::sat32(emit_end);
    new_item.last_of_run    = 1'b0;

    flush_item             = staged_r;
    flush_item.last_of_run = 1'b1;

    sts.pend_valid   = pend_valid_r;
    sts.last         = last_r;
    sts.k_done       = k_r >= oc;
    sts.a_ok         = 32'(out_a) < acwpm_pkg::OUTPUT_DEPTH;
    sts.pat_ok       = 32'(out_q) < acwpm_pkg::PATTERN_DEPTH;
    sts.len_ok       = (len_q != 9'd0) && (32'(len_q) <= acwpm_pkg::MAX_PATTERN_LEN) &&
                       ({24'b0, len_q} <= emit_end);
    sts.suppress     = !cmd.em_final && w_r;
    sts.need_before  = {24'b0, len_q} < emit_end;
    sts.hist_flag    = hist_q;
    sts.newest       = newest_r;
    sts.limit        = 32'(cnt_r) >= acwpm_pkg::RESULT_LIMIT;
    sts.staged_valid = staged_valid_r;
    sts.out_space    = out_space;
    sts.t_done       = (i_r >= tc) || !(32'(trans_a) < acwpm_pkg::TRANSITION_DEPTH);
    sts.s_zero       = s_r == '0;
    sts.steps_max    = 32'(steps_r) >= acwpm_pkg::NODE_DEPTH;
    sts.key_hit      = trans_q.key == c_r;
  end

  // tables
  always_ff @(posedge clk) begin
    if (cmd.load && in_data.mode == acwpm_pkg::MODE_NODE && in_node_ok) begin
      node_mem[in_data.index[acwpm_pkg::NODE_AW-1:0]] <= node_wd;
    end
    if (cmd.node_rd) begin
      node_q <= node_mem[node_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && in_data.mode == acwpm_pkg::MODE_TRANS && in_trans_ok) begin
      trans_mem[in_data.index[acwpm_pkg::TRANS_AW-1:0]] <=
        {in_data.byte_value, in_data.target_value};
    end
    if (cmd.trans_rd) begin
      trans_q <= trans_mem[trans_a[acwpm_pkg::TRANS_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && in_data.mode == acwpm_pkg::MODE_OUT && in_out_ok) begin
      olist_mem[in_data.index[acwpm_pkg::OUT_AW-1:0]] <= in_data.target_value[9:0];
    end
    if (cmd.out_rd) begin
      out_q <= olist_mem[out_a[acwpm_pkg::OUT_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && in_data.mode == acwpm_pkg::MODE_LEN && in_len_ok) begin
      plen_mem[in_data.index[acwpm_pkg::PAT_AW-1:0]] <= in_data.target_value[8:0];
    end
    if (cmd.len_rd) begin
      len_q <= plen_mem[out_q[acwpm_pkg::PAT_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hist_wr) begin
      hist_mem[head_inc] <= w_r;
    end
    if (cmd.hist_rd) begin
      hist_q <= hist_mem[ha];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_node_r     <= '0;
      pos_r          <= '0;
      pend_valid_r   <= 1'b0;
      pend_node_r    <= '0;
      pend_end_r     <= '0;
      head_r         <= '0;
      cnt_r          <= '0;
      staged_valid_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cmd.text_start) begin
        cnt_r <= '0;
      end
      if (cmd.hist_wr) begin
        head_r <= head_inc;
      end
      if (cmd.update) begin
        cur_node_r <= nxt_r;
        pos_r      <= acwpm_pkg::sat32(end_nxt);
        if (!last_r) begin
          pend_valid_r <= 1'b1;
          pend_node_r  <= nxt_r;
          pend_end_r   <= end_nxt;
        end
      end
      if (cmd.clear) begin
        cur_node_r   <= '0;
        pos_r        <= '0;
        pend_valid_r <= 1'b0;
        pend_node_r  <= '0;
        pend_end_r   <= '0;
        head_r       <= '0;
      end
      // a new transfer into the output register wins over the drain
      if ((cmd.push && staged_valid_r) || cmd.flush) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.push) begin
        cnt_r          <= cnt_r + 1'b1;
        staged_valid_r <= 1'b1;
      end
      if (cmd.flush) begin
        staged_valid_r <= 1'b0;
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    if (cmd.text_start) begin
      c_r    <= in_data.byte_value;
      last_r <= in_data.last_byte;
      w_r    <= acwpm_pkg::is_word(in_data.byte_value);
    end
    if (cmd.hist_wr) begin
      newest_r <= w_r;
      s_r      <= cur_node_r;
      steps_r  <= '0;
    end
    if (cmd.node_rd) begin
      i_r <= '0;
      k_r <= '0;
    end
    if (cmd.k_inc) begin
      k_r <= k_r + 1'b1;
    end
    if (cmd.i_inc) begin
      i_r <= i_r + 1'b1;
    end
    if (cmd.wk_fail) begin
      s_r     <= acwpm_pkg::node_ref(node_q.fail);
      steps_r <= steps_r + 1'b1;
    end
    if (cmd.wk_root) begin
      s_r <= '0;
    end
    if (cmd.nxt_hit) begin
      nxt_r <= acwpm_pkg::node_ref(trans_q.target);
    end
    if (cmd.nxt_zero) begin
      nxt_r <= '0;
    end
    if (cmd.update) begin
      end_r <= end_nxt;
    end
    if (cmd.push) begin
      staged_r <= new_item;
      if (staged_valid_r) begin
        out_r <= staged_r;
      end
    end
    if (cmd.flush) begin
      out_r <= flush_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

### design/acwpm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acwpm_ctrl
// Sequencer for loads, match scans, failure walk and result flush.
// ----------------------------------------------------------------------------
module acwpm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_mode,
  input  acwpm_pkg::sts_t   sts,
  output acwpm_pkg::cmd_t   cmd
);

  acwpm_pkg::state_t state_r, state_nxt;
  logic              phase_r, phase_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= acwpm_pkg::ST_IDLE;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    cmd          = '0;
    cmd.em_final = phase_r;
    in_ready     = state_r == acwpm_pkg::ST_IDLE;
    unique case (state_r)
      acwpm_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_mode == acwpm_pkg::MODE_TEXT) begin
            cmd.text_start = 1'b1;
            phase_nxt      = 1'b0;
            state_nxt      = sts.pend_valid ? acwpm_pkg::ST_EM_NODE : acwpm_pkg::ST_HIST_WR;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      acwpm_pkg::ST_EM_NODE: begin
        cmd.node_rd = 1'b1;
        state_nxt   = acwpm_pkg::ST_EM_SCAN;
      end
      acwpm_pkg::ST_EM_SCAN: begin
        if (sts.k_done) begin
          if (phase_r) begin
            cmd.clear = 1'b1;
            state_nxt = acwpm_pkg::ST_FLUSH;
          end else begin
            state_nxt = acwpm_pkg::ST_HIST_WR;
          end
        end else if (!sts.a_ok) begin
          cmd.k_inc = 1'b1;
        end else begin
          cmd.out_rd = 1'b1;
          state_nxt  = acwpm_pkg::ST_EM_PAT;
        end
      end
      acwpm_pkg::ST_EM_PAT: begin
        if (!sts.pat_ok) begin
          cmd.k_inc = 1'b1;
          state_nxt = acwpm_pkg::ST_EM_SCAN;
        end else begin
          cmd.len_rd = 1'b1;
          state_nxt  = acwpm_pkg::ST_EM_LEN;
        end
      end
      acwpm_pkg::ST_EM_LEN: begin
        if (!sts.len_ok || sts.suppress) begin
          cmd.k_inc = 1'b1;
          state_nxt = acwpm_pkg::ST_EM_SCAN;
        end else if (sts.need_before) begin
          cmd.hist_rd = 1'b1;
          state_nxt   = acwpm_pkg::ST_EM_HB;
        end else begin
          cmd.hist_rd  = 1'b1;
          cmd.hist_sel = 1'b1;
          state_nxt    = acwpm_pkg::ST_EM_HE;
        end
      end
      acwpm_pkg::ST_EM_HB: begin
        // word character right before the match: drop it
        if (sts.hist_flag) begin
          cmd.k_inc = 1'b1;
          state_nxt = acwpm_pkg::ST_EM_SCAN;
        end else begin
          cmd.hist_rd  = 1'b1;
          cmd.hist_sel = 1'b1;
          state_nxt    = acwpm_pkg::ST_EM_HE;
        end
      end
      acwpm_pkg::ST_EM_HE: begin
        if (!sts.hist_flag || !sts.newest || sts.limit) begin
          cmd.k_inc = 1'b1;
          state_nxt = acwpm_pkg::ST_EM_SCAN;
        end else begin
          state_nxt = acwpm_pkg::ST_EM_PUSH;
        end
      end
      acwpm_pkg::ST_EM_PUSH: begin
        // hold until the staged result can move to the output register
        if (!sts.staged_valid || sts.out_space) begin
          cmd.push  = 1'b1;
          cmd.k_inc = 1'b1;
          state_nxt = acwpm_pkg::ST_EM_SCAN;
        end
      end
      acwpm_pkg::ST_HIST_WR: begin
        cmd.hist_wr = 1'b1;
        state_nxt   = acwpm_pkg::ST_WK_NODE;
      end
      acwpm_pkg::ST_WK_NODE: begin
        cmd.node_rd       = 1'b1;
        cmd.node_sel_walk = 1'b1;
        state_nxt         = acwpm_pkg::ST_WK_SCAN;
      end
      acwpm_pkg::ST_WK_SCAN: begin
        cmd.node_sel_walk = 1'b1;
        if (sts.t_done) begin
          if (sts.s_zero) begin
            cmd.nxt_zero = 1'b1;
            state_nxt    = acwpm_pkg::ST_UPDATE;
          end else if (sts.steps_max) begin
            cmd.wk_root = 1'b1;
            state_nxt   = acwpm_pkg::ST_WK_NODE;
          end else begin
            cmd.wk_fail = 1'b1;
            state_nxt   = acwpm_pkg::ST_WK_NODE;
          end
        end else begin
          cmd.trans_rd = 1'b1;
          state_nxt    = acwpm_pkg::ST_WK_KEY;
        end
      end
      acwpm_pkg::ST_WK_KEY: begin
        if (sts.key_hit) begin
          cmd.nxt_hit = 1'b1;
          state_nxt   = acwpm_pkg::ST_UPDATE;
        end else begin
          cmd.i_inc = 1'b1;
          state_nxt = acwpm_pkg::ST_WK_SCAN;
        end
      end
      acwpm_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        if (sts.last) begin
          phase_nxt = 1'b1;
          state_nxt = acwpm_pkg::ST_EM_NODE;
        end else begin
          state_nxt = acwpm_pkg::ST_FLUSH;
        end
      end
      acwpm_pkg::ST_FLUSH: begin
        if (!sts.staged_valid) begin
          state_nxt = acwpm_pkg::ST_IDLE;
        end else if (sts.out_space) begin
          cmd.flush = 1'b1;
          state_nxt = acwpm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = acwpm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### design/aho_corasick_word_phrase_matcher_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aho_corasick_word_phrase_matcher_unit
// Multi-pattern phrase matcher with word-boundary filtering. Load items
// (node, transition, output entry, pattern length) are written as they
// are accepted. A text byte scans the transition entries of its node and
// follows failure links until a key matches or the root is reached; the
// pending node before the walk and, on the last byte, the reached node
// after it each have their output lists scanned. Every table is a
// single-port memory with a registered read, and the sequencer makes one
// table access at a time. Results leave through a one-entry stage plus an
// output register, so a full output stalls the scan.
// ----------------------------------------------------------------------------
`include "aho_corasick_word_phrase_matcher_unit_assert.svh"

module aho_corasick_word_phrase_matcher_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  acwpm_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output acwpm_pkg::out_item_t out_data
);

  acwpm_pkg::cmd_t cmd;
  acwpm_pkg::sts_t sts;
  logic            text_acc;

  acwpm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_mode  (in_data.mode),
    .sts      (sts),
    .cmd      (cmd)
  );

  acwpm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign text_acc = in_valid && in_ready && in_data.mode == acwpm_pkg::MODE_TEXT;

  `ACWPM_ASSERT_IMP(a_idle_no_staged, in_ready, !sts.staged_valid)
  `ACWPM_ASSERT_NXT(a_text_busy, text_acc, !in_ready)
  `ACWPM_ASSERT_IMP(a_push_limit, cmd.push, !sts.limit)

endmodule
`default_nettype wire
